[hw/rtl/ffsc_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package ffsc_pkg;

  localparam int FRAME_LENGTH = 30;
  localparam int POS_W        = $clog2(FRAME_LENGTH);
  localparam int OFFSET_W     = 5;

  typedef logic [7:0]          byte_t;
  typedef logic [POS_W-1:0]    pos_t;
  typedef logic [OFFSET_W-1:0] offset_t;
  typedef logic [1:0]          kind_t;
  typedef logic [1:0]          cfg_idx_t;

  localparam kind_t KIND_COMMAND  = 2'd0;
  localparam kind_t KIND_REALTIME = 2'd1;
  localparam kind_t KIND_OTHER    = 2'd2;

  localparam cfg_idx_t CFG_HEADER_FIRST  = 2'd0;
  localparam cfg_idx_t CFG_HEADER_SECOND = 2'd1;
  localparam cfg_idx_t CFG_LINK_MODE     = 2'd2;

  localparam byte_t HEADER_FIRST_RST  = 8'h55;
  localparam byte_t HEADER_SECOND_RST = 8'hAA;
  localparam byte_t LINK_MODE_RST     = 8'h02;

  localparam byte_t CMD_LOW      = 8'hB0;
  localparam byte_t CMD_HIGH     = 8'hBF;
  localparam byte_t REALTIME_CMD = 8'h00;

  // Classify a frame from its command byte.
  function automatic kind_t kind_of(input byte_t code);
    kind_t k;
    if (code >= CMD_LOW && code <= CMD_HIGH) begin
      k = KIND_COMMAND;
    end else if (code == REALTIME_CMD) begin
      k = KIND_REALTIME;
    end else begin
      k = KIND_OTHER;
    end
    return k;
  endfunction

endpackage
`default_nettype wire

[hw/rtl/ffsc_if.sv]
`timescale 1ns / 1ps
`default_nettype none
interface ffsc_in_if;
  logic                valid;
  logic                ready;
  ffsc_pkg::byte_t     rx_byte;
  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface ffsc_out_if;
  logic                valid;
  logic                ready;
  ffsc_pkg::byte_t     frame_byte;
  ffsc_pkg::offset_t   byte_offset;
  ffsc_pkg::kind_t     frame_kind;
  logic                last_of_frame;
  modport source (output valid, output frame_byte, output byte_offset,
                  output frame_kind, output last_of_frame, input ready);
  modport sink   (input valid, input frame_byte, input byte_offset,
                  input frame_kind, input last_of_frame, output ready);
endinterface

interface ffsc_cfg_if;
  logic                 valid;
  logic                 ready;
  ffsc_pkg::cfg_idx_t   addr;
  ffsc_pkg::byte_t      data;
  modport source (output valid, output addr, output data, input ready);
  modport sink   (input valid, input addr, input data, output ready);
endinterface
`default_nettype wire

[hw/rtl/ffsc_cell.sv]
`timescale 1ns / 1ps
`default_nettype none
// One byte of the frame chain; takes its neighbour's byte on each shift.
module ffsc_cell (
  input  wire logic            clk,
  input  wire logic            shift,
  input  wire ffsc_pkg::byte_t d,
  output ffsc_pkg::byte_t      q
);
  import ffsc_pkg::*;

  byte_t data_r;

  always_ff @(posedge clk) begin
    if (shift) begin
      data_r <= d;
    end
  end

  assign q = data_r;

endmodule
`default_nettype wire

[hw/rtl/fixed_frame_sync_checksum_parser.sv]
`timescale 1ns / 1ps
`default_nettype none
// Fixed-length frame synchroniser with an additive 8-bit checksum.
// Received bytes arrive on the input channel, one per transfer. The block hunts
// for the two header bytes, then gathers the rest of a FRAME_LENGTH-byte frame
// into a chain of byte cells. A frame passes when byte 2 equals the link-mode
// register and the 8-bit sum of bytes 2 to FRAME_LENGTH-2 equals the last byte.
// A passing frame is sent on the output channel as FRAME_LENGTH transfers, byte
// 0 first, each with its offset, the frame kind and a last flag; a failing
// frame is dropped without any output.
// Throughput: while gathering, one input byte is taken every cycle. The last
// byte of a good frame starts a burst of FRAME_LENGTH output transfers, one per
// cycle when the receiver is ready; the cell chain shifts one place per output
// transfer and input is held off until the burst ends. The first output byte is
// offered on the cycle after the final input byte.
// A receiver stall simply holds the current output byte; nothing is lost.
// The configuration channel is always ready; register i of the list takes the
// data at address i, and the unused address is ignored.
// Reset (rst_n low, synchronous) returns to the hunt for the first header byte
// and restores the header and link-mode registers to their default values.
module fixed_frame_sync_checksum_parser (
  input  wire logic   clk,
  input  wire logic   rst_n,
  ffsc_in_if.sink     in_ch,
  ffsc_out_if.source  out_ch,
  ffsc_cfg_if.sink    cfg_ch
);
  import ffsc_pkg::*;

  localparam logic ST_COLLECT = 1'b0;
  localparam logic ST_EMIT    = 1'b1;

  logic  state_r, state_nxt;
  pos_t  fill_pos_r, fill_pos_nxt;
  pos_t  emit_cnt_r, emit_cnt_nxt;
  byte_t sum_r, sum_nxt;
  kind_t kind_r, kind_nxt;
  byte_t header_first_r, header_second_r, link_mode_r;

  logic  in_xfer, out_xfer, shift;
  byte_t chain_in;
  byte_t cell_q [FRAME_LENGTH];

  assign in_ch.ready  = (state_r == ST_COLLECT);
  assign in_xfer      = in_ch.valid && in_ch.ready;
  assign out_xfer     = out_ch.valid && out_ch.ready;
  assign cfg_ch.ready = 1'b1;

  // Every received byte enters the tail of the chain; each output transfer
  // moves the frame one cell toward the head, where byte 0 sits.
  assign shift    = in_xfer || out_xfer;
  assign chain_in = in_xfer ? in_ch.rx_byte : '0;

  for (genvar g = 0; g < FRAME_LENGTH; g++) begin : g_cell
    if (g == FRAME_LENGTH - 1) begin : g_tail
      ffsc_cell u_cell (.clk(clk), .shift(shift), .d(chain_in), .q(cell_q[g]));
    end else begin : g_body
      ffsc_cell u_cell (.clk(clk), .shift(shift), .d(cell_q[g+1]), .q(cell_q[g]));
    end
  end

  // Frame control. On the final input byte the chain has not yet shifted, so
  // frame byte k still sits in cell k+1.
  always_comb begin
    state_nxt    = state_r;
    fill_pos_nxt = fill_pos_r;
    emit_cnt_nxt = emit_cnt_r;
    sum_nxt      = sum_r;
    kind_nxt     = kind_r;
    case (state_r)
      ST_COLLECT: begin
        if (in_xfer) begin
          if (fill_pos_r == '0) begin
            if (in_ch.rx_byte == header_first_r) begin
              fill_pos_nxt = pos_t'(1);
              sum_nxt      = '0;
            end
          end else if (fill_pos_r == pos_t'(1)) begin
            // A wrong second header byte is dropped even if it would start a frame.
            fill_pos_nxt = (in_ch.rx_byte == header_second_r) ? pos_t'(2) : '0;
          end else if (fill_pos_r == pos_t'(FRAME_LENGTH - 1)) begin
            fill_pos_nxt = '0;
            if (cell_q[3] == link_mode_r && sum_r == in_ch.rx_byte) begin
              state_nxt    = ST_EMIT;
              emit_cnt_nxt = '0;
              kind_nxt     = kind_of(cell_q[4]);
            end
          end else begin
            sum_nxt      = sum_r + in_ch.rx_byte;
            fill_pos_nxt = fill_pos_r + pos_t'(1);
          end
        end
      end
      ST_EMIT: begin
        if (out_xfer) begin
          if (emit_cnt_r == pos_t'(FRAME_LENGTH - 1)) begin
            state_nxt    = ST_COLLECT;
            emit_cnt_nxt = '0;
          end else begin
            emit_cnt_nxt = emit_cnt_r + pos_t'(1);
          end
        end
      end
      default: begin
        state_nxt = ST_COLLECT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= ST_COLLECT;
      fill_pos_r      <= '0;
      emit_cnt_r      <= '0;
      sum_r           <= '0;
      header_first_r  <= HEADER_FIRST_RST;
      header_second_r <= HEADER_SECOND_RST;
      link_mode_r     <= LINK_MODE_RST;
    end else begin
      state_r    <= state_nxt;
      fill_pos_r <= fill_pos_nxt;
      emit_cnt_r <= emit_cnt_nxt;
      sum_r      <= sum_nxt;
      if (cfg_ch.valid && cfg_ch.ready) begin
        case (cfg_ch.addr)
          CFG_HEADER_FIRST:  header_first_r  <= cfg_ch.data;
          CFG_HEADER_SECOND: header_second_r <= cfg_ch.data;
          CFG_LINK_MODE:     link_mode_r     <= cfg_ch.data;
          default: begin
          end
        endcase
      end
    end
  end

  // The kind is only meaningful during a burst, so it needs no reset.
  always_ff @(posedge clk) begin
    kind_r <= kind_nxt;
  end

  assign out_ch.valid         = (state_r == ST_EMIT);
  assign out_ch.frame_byte    = cell_q[0];
  assign out_ch.byte_offset   = offset_t'(emit_cnt_r);
  assign out_ch.frame_kind    = kind_r;
  assign out_ch.last_of_frame = (emit_cnt_r == pos_t'(FRAME_LENGTH - 1));

  // A burst only ever starts from the hunt for a new header.
  a_emit_from_hunt: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EMIT) |-> (fill_pos_r == '0))
    else $error("burst running while a frame is partly gathered");

  // The final transfer of a burst hands the block back to the input side.
  a_last_ends_burst: assert property (@(posedge clk) disable iff (!rst_n)
    (out_xfer && out_ch.last_of_frame) |=> (in_ch.ready && !out_ch.valid))
    else $error("burst did not end after its last byte");

  // Every burst starts at offset zero.
  a_burst_starts_at_zero: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_ch.valid) |-> (emit_cnt_r == '0))
    else $error("burst started at a non-zero offset");

  // A good frame's final byte opens a burst on the next cycle.
  a_good_frame_emits: assert property (@(posedge clk) disable iff (!rst_n)
    (in_xfer && fill_pos_r == pos_t'(FRAME_LENGTH - 1) && cell_q[3] == link_mode_r
     && sum_r == in_ch.rx_byte) |=> out_ch.valid)
    else $error("good frame produced no burst");

endmodule
`default_nettype wire

[sim/ffsc_frame_checker.sv]
`timescale 1ns / 1ps
module ffsc_frame_checker (
  input  logic clk,
  input  logic rst_n,
  ffsc_in_if   in_ch,
  ffsc_out_if  out_ch,
  ffsc_cfg_if  cfg_ch,
  output int   error_count,
  output int   pending_count
);
  import ffsc_pkg::*;

  localparam int PRINT_CAP = 50;

  typedef struct packed {
    byte_t   data;
    offset_t offset;
    kind_t   kind;
    logic    last;
  } frame_out_t;

  byte_t       sync_first;
  byte_t       sync_second;
  byte_t       link_mode;
  int unsigned fill_pos;
  byte_t       frame_buf [FRAME_LENGTH];
  byte_t       check_sum;
  frame_out_t  awaited_bytes [$];

  initial begin
    error_count   = 0;
    pending_count = 0;
  end

  function automatic kind_t classify(input byte_t code);
    kind_t k;
    if (code >= CMD_LOW && code <= CMD_HIGH) begin
      k = KIND_COMMAND;
    end else if (code == REALTIME_CMD) begin
      k = KIND_REALTIME;
    end else begin
      k = KIND_OTHER;
    end
    return k;
  endfunction

  task automatic report(input string msg);
    if (error_count < PRINT_CAP) begin
      $display("[%0t] frame checker: %s", $realtime, msg);
    end
    error_count++;
  endtask

  // One received byte moves the hunt and fill state on; a completed frame that
  // passes both tests queues all of its bytes as awaited output transfers.
  task automatic take_rx(input byte_t b);
    kind_t k;
    if (fill_pos == 0) begin
      if (b == sync_first) begin
        frame_buf[0] = b;
        check_sum    = '0;
        fill_pos     = 1;
      end
    end else if (fill_pos == 1) begin
      if (b != sync_second) begin
        fill_pos = 0;
      end else begin
        frame_buf[1] = b;
        fill_pos     = 2;
      end
    end else begin
      frame_buf[fill_pos] = b;
      if (fill_pos <= FRAME_LENGTH - 2) begin
        check_sum = check_sum + b;
      end
      fill_pos++;
      if (fill_pos == FRAME_LENGTH) begin
        fill_pos = 0;
        if (frame_buf[2] == link_mode && check_sum == frame_buf[FRAME_LENGTH-1]) begin
          k = classify(frame_buf[3]);
          for (int i = 0; i < FRAME_LENGTH; i++) begin
            awaited_bytes.push_back('{frame_buf[i], offset_t'(i), k, i == FRAME_LENGTH - 1});
          end
        end
      end
    end
  endtask

  task automatic check_out();
    frame_out_t want;
    if (awaited_bytes.size() == 0) begin
      report($sformatf("unexpected output byte %02h at offset %0d",
                       out_ch.frame_byte, out_ch.byte_offset));
    end else begin
      want = awaited_bytes.pop_front();
      if (out_ch.frame_byte !== want.data) begin
        report($sformatf("frame_byte %02h, expected %02h at offset %0d",
                         out_ch.frame_byte, want.data, want.offset));
      end
      if (out_ch.byte_offset !== want.offset) begin
        report($sformatf("byte_offset %0d, expected %0d", out_ch.byte_offset, want.offset));
      end
      if (out_ch.frame_kind !== want.kind) begin
        report($sformatf("frame_kind %0d, expected %0d at offset %0d",
                         out_ch.frame_kind, want.kind, want.offset));
      end
      if (out_ch.last_of_frame !== want.last) begin
        report($sformatf("last_of_frame %b, expected %b at offset %0d",
                         out_ch.last_of_frame, want.last, want.offset));
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      sync_first  = HEADER_FIRST_RST;
      sync_second = HEADER_SECOND_RST;
      link_mode   = LINK_MODE_RST;
      fill_pos    = 0;
      check_sum   = '0;
      awaited_bytes.delete();
    end else begin
      if (cfg_ch.valid === 1'b1 && cfg_ch.ready === 1'b1) begin
        if (cfg_ch.addr == CFG_HEADER_FIRST) begin
          sync_first = cfg_ch.data;
        end else if (cfg_ch.addr == CFG_HEADER_SECOND) begin
          sync_second = cfg_ch.data;
        end else if (cfg_ch.addr == CFG_LINK_MODE) begin
          link_mode = cfg_ch.data;
        end
      end
      // Outputs are compared before this edge's input is taken: a frame's
      // first byte is never offered on the cycle of its final input byte.
      if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
        check_out();
      end
      if (in_ch.valid === 1'b1 && in_ch.ready === 1'b1) begin
        take_rx(in_ch.rx_byte);
      end
    end
    pending_count = awaited_bytes.size();
  end

endmodule

[sim/fixed_frame_sync_checksum_parser_tb.sv]
`timescale 1ns / 1ps
module fixed_frame_sync_checksum_parser_tb;
  import ffsc_pkg::*;

  localparam int          CLK_HALF      = 6;
  localparam int          RESET_CYCLES  = 11;
  // Spare cycles after the last awaited transfer before a register write or
  // the verdict; a dropped frame leaves nothing to wait on otherwise.
  localparam int          SETTLE_CYCLES = 8;
  localparam int unsigned CYCLE_LIMIT   = 2_000_000;
  localparam int          PHASES        = 5;
  localparam int unsigned PHASE_ITEMS   = 24;
  // The one address that maps to no register.
  localparam cfg_idx_t    CFG_SPARE     = 2'd3;

  typedef enum int {
    FRAME_GOOD,
    FRAME_BAD_SUM,
    FRAME_BAD_MODE,
    FRAME_BAD_SECOND
  } frame_fault_t;

  typedef byte_t frame_t [FRAME_LENGTH];

  logic        clk   = 1'b0;
  logic        rst_n = 1'b0;
  int          pending_results;
  int          error_total;
  int unsigned cycle_count = 0;
  int unsigned bytes_sent  = 0;
  // The register values last written; the stimulus uses them to build frames.
  byte_t       cur_first  = HEADER_FIRST_RST;
  byte_t       cur_second = HEADER_SECOND_RST;
  byte_t       cur_mode   = LINK_MODE_RST;
  // When set, the sender offers bytes back to back with no gaps.
  bit          sender_burst = 1'b0;

  ffsc_in_if  in_ch();
  ffsc_out_if out_ch();
  ffsc_cfg_if cfg_ch();

  always begin
    #CLK_HALF clk = 1'b1;
    #CLK_HALF clk = 1'b0;
  end

  fixed_frame_sync_checksum_parser u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  ffsc_frame_checker u_check (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_ch         (in_ch),
    .out_ch        (out_ch),
    .cfg_ch        (cfg_ch),
    .error_count   (error_total),
    .pending_count (pending_results)
  );

  // A gap length: mostly from the shortest band, sometimes longer, rarely long.
  function automatic int unsigned gap_length();
    int unsigned roll;
    int unsigned len;
    roll = $urandom_range(0, 99);
    if (roll < 75) begin
      len = $urandom_range(1, 3);
    end else if (roll < 95) begin
      len = $urandom_range(4, 12);
    end else begin
      len = $urandom_range(20, 60);
    end
    return len;
  endfunction

  // The receiver stalls at random, with occasional long stretches of constant
  // readiness, so that stalls land on every byte of an output burst.
  initial begin : sink_pacing
    int unsigned stall_left;
    int unsigned free_left;
    int unsigned roll;
    logic        rdy;
    stall_left   = 0;
    free_left    = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (free_left > 0) begin
        free_left--;
        rdy = 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        rdy = 1'b0;
      end else begin
        rdy  = 1'b1;
        roll = $urandom_range(0, 99);
        if (roll < 3) begin
          free_left = $urandom_range(50, 200);
        end else if (roll < 30) begin
          stall_left = gap_length();
        end
      end
      out_ch.ready <= rdy;
    end
  end

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("fixed_frame_sync_checksum_parser_tb: done, errors");
      $finish;
    end
  end

  // Offers one byte, after an optional gap, and returns once the transfer has
  // taken place. Valid is left high so that the next byte can follow directly.
  task automatic push_byte(input byte_t value);
    int unsigned idle;
    idle = 0;
    if (!sender_burst && $urandom_range(0, 99) >= 55) begin
      idle = gap_length();
    end
    if (idle > 0) begin
      in_ch.valid <= 1'b0;
      repeat (idle) @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.rx_byte <= value;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    bytes_sent++;
  endtask

  // Holds the sender off until every awaited output transfer has been seen,
  // then lets the block settle. The count is sampled on the falling edge so
  // that it never races the checker's update at the rising edge.
  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    do @(negedge clk); while (pending_results != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Valid stays high across consecutive writes; the caller lowers it once.
  task automatic cfg_write(input cfg_idx_t idx, input byte_t value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.addr  <= idx;
    cfg_ch.data  <= value;
    do @(posedge clk); while (cfg_ch.ready !== 1'b1);
    if (idx == CFG_HEADER_FIRST) begin
      cur_first = value;
    end else if (idx == CFG_HEADER_SECOND) begin
      cur_second = value;
    end else if (idx == CFG_LINK_MODE) begin
      cur_mode = value;
    end
  endtask

  task automatic set_regs(input byte_t first, input byte_t second, input byte_t mode);
    cfg_write(CFG_HEADER_FIRST, first);
    cfg_write(CFG_HEADER_SECOND, second);
    cfg_write(CFG_LINK_MODE, mode);
    cfg_ch.valid <= 1'b0;
  endtask

  // Recomputes the trailing checksum over bytes 2 to FRAME_LENGTH-2; a corrupt
  // frame gets a checksum that is off by a non-zero pattern.
  task automatic seal_frame(inout frame_t f, input bit corrupt);
    byte_t sum;
    sum = '0;
    for (int i = 2; i < FRAME_LENGTH - 1; i++) begin
      sum = sum + f[i];
    end
    if (corrupt) begin
      sum = sum ^ byte_t'($urandom_range(1, 255));
    end
    f[FRAME_LENGTH-1] = sum;
  endtask

  task automatic build_frame(input frame_fault_t fault, input byte_t mode,
                             input byte_t code, output frame_t f);
    f[0] = cur_first;
    f[1] = cur_second;
    if (fault == FRAME_BAD_SECOND) begin
      f[1] = cur_second ^ byte_t'($urandom_range(1, 255));
    end
    f[2] = mode;
    if (fault == FRAME_BAD_MODE) begin
      f[2] = mode ^ byte_t'($urandom_range(1, 255));
    end
    f[3] = code;
    for (int i = 4; i < FRAME_LENGTH - 1; i++) begin
      f[i] = byte_t'($urandom_range(0, 255));
    end
    seal_frame(f, fault == FRAME_BAD_SUM);
  endtask

  task automatic push_frame(input frame_t f, input int from_idx, input int to_idx);
    for (int i = from_idx; i <= to_idx; i++) begin
      push_byte(f[i]);
    end
  endtask

  // Command bytes cluster on the edges of the command range and on zero.
  function automatic byte_t pick_code();
    byte_t code;
    case ($urandom_range(0, 7))
      0: code = CMD_LOW;
      1: code = CMD_HIGH;
      2: code = REALTIME_CMD;
      3: code = CMD_LOW - 8'd1;
      4: code = CMD_HIGH + 8'd1;
      5: code = CMD_LOW | byte_t'($urandom_range(0, 15));
      6: code = 8'h01;
      default: code = byte_t'($urandom_range(0, 255));
    endcase
    return code;
  endfunction

  initial begin : stimulus
    frame_t      f;
    int unsigned roll;
    int unsigned target;
    byte_t       h;

    in_ch.valid   = 1'b0;
    in_ch.rx_byte = '0;
    cfg_ch.valid  = 1'b0;
    cfg_ch.addr   = CFG_HEADER_FIRST;
    cfg_ch.data   = '0;

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // A write to the spare address must leave every register at its default,
    // which the good frames below rely on.
    cfg_write(CFG_SPARE, 8'h3C);
    cfg_ch.valid <= 1'b0;

    // Line noise at both extremes, then a first header byte followed by a
    // second copy of itself: the copy is a wrong second byte, so it is
    // dropped and the hunt restarts rather than treating it as a new start.
    push_byte(8'h00);
    push_byte(8'hFF);
    push_byte(cur_first);
    push_byte(cur_first);
    push_byte(cur_second);

    // A good command frame at the top of the command range, with payload
    // bytes at both extremes.
    build_frame(FRAME_GOOD, cur_mode, CMD_HIGH, f);
    f[4] = 8'h00;
    f[5] = 8'hFF;
    seal_frame(f, 1'b0);
    push_frame(f, 0, FRAME_LENGTH - 1);

    // Realtime frame and a frame just below the command range.
    build_frame(FRAME_GOOD, cur_mode, REALTIME_CMD, f);
    push_frame(f, 0, FRAME_LENGTH - 1);
    build_frame(FRAME_GOOD, cur_mode, CMD_LOW - 8'd1, f);
    push_frame(f, 0, FRAME_LENGTH - 1);

    // Frames that must vanish: bad checksum, bad link mode, bad second header.
    build_frame(FRAME_BAD_SUM, cur_mode, CMD_LOW, f);
    push_frame(f, 0, FRAME_LENGTH - 1);
    build_frame(FRAME_BAD_MODE, cur_mode, CMD_LOW, f);
    push_frame(f, 0, FRAME_LENGTH - 1);
    build_frame(FRAME_BAD_SECOND, cur_mode, CMD_LOW, f);
    push_frame(f, 0, FRAME_LENGTH - 1);

    // Link mode changed part-way through a frame: the frame carries the new
    // mode and passes only because the test is made against the new value.
    // The sender also holds off here until all output has drained.
    wait_idle();
    build_frame(FRAME_GOOD, 8'h37, CMD_LOW, f);
    push_frame(f, 0, 11);
    wait_idle();
    cfg_write(CFG_LINK_MODE, 8'h37);
    cfg_ch.valid <= 1'b0;
    push_frame(f, 12, FRAME_LENGTH - 1);

    // Random phases, each under its own register setting: the defaults, the
    // two extremes, equal header bytes and a fully random setting.
    target = bytes_sent;
    for (int p = 0; p < PHASES; p++) begin
      wait_idle();
      case (p)
        0: set_regs(HEADER_FIRST_RST, HEADER_SECOND_RST, LINK_MODE_RST);
        1: set_regs(8'h00, 8'hFF, 8'hFF);
        2: set_regs(8'hFF, 8'h00, 8'h00);
        3: begin
          h = byte_t'($urandom_range(0, 255));
          set_regs(h, h, byte_t'($urandom_range(0, 255)));
        end
        default: set_regs(byte_t'($urandom_range(0, 255)), byte_t'($urandom_range(0, 255)),
                          byte_t'($urandom_range(0, 255)));
      endcase
      target = target + PHASE_ITEMS;
      while (bytes_sent < target) begin
        sender_burst = ($urandom_range(0, 3) == 0);
        roll = $urandom_range(0, 99);
        if (roll < 62) begin
          build_frame(FRAME_GOOD, cur_mode, pick_code(), f);
          push_frame(f, 0, FRAME_LENGTH - 1);
        end else if (roll < 70) begin
          build_frame(FRAME_BAD_SUM, cur_mode, pick_code(), f);
          push_frame(f, 0, FRAME_LENGTH - 1);
        end else if (roll < 76) begin
          build_frame(FRAME_BAD_MODE, cur_mode, pick_code(), f);
          push_frame(f, 0, FRAME_LENGTH - 1);
        end else if (roll < 82) begin
          build_frame(FRAME_BAD_SECOND, cur_mode, pick_code(), f);
          push_frame(f, 0, FRAME_LENGTH - 1);
        end else if (roll < 88) begin
          // A frame cut short; whatever follows is swallowed as its tail.
          build_frame(FRAME_GOOD, cur_mode, pick_code(), f);
          push_frame(f, 0, $urandom_range(2, FRAME_LENGTH - 2));
        end else if (roll < 97) begin
          repeat ($urandom_range(1, 6)) push_byte(byte_t'($urandom_range(0, 255)));
        end else begin
          wait_idle();
        end
      end
    end

    sender_burst = 1'b0;
    wait_idle();
    if (error_total == 0) begin
      $display("fixed_frame_sync_checksum_parser_tb: done, clean");
    end else begin
      $display("fixed_frame_sync_checksum_parser_tb: done, errors");
    end
    $finish;
  end

endmodule

[sim.f]
hw/rtl/ffsc_pkg.sv
hw/rtl/ffsc_if.sv
hw/rtl/ffsc_cell.sv
hw/rtl/fixed_frame_sync_checksum_parser.sv
sim/ffsc_frame_checker.sv
sim/fixed_frame_sync_checksum_parser_tb.sv
